>>> rtl/core/mpq_pkg.sv
// Shared types and constants for the sorted min priority queue.
package mpq_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int DATA_W      = 32;
    localparam int PRIO_W      = 8;
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic
    {
        OP_INSERT = 1'b0,
        OP_REMOVE = 1'b1
    } opcode_t;

    typedef enum logic [1:0]
    {
        ST_DONE  = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    // Command from the controller to the datapath for one accepted transfer.
    typedef enum logic [2:0]
    {
        CMD_IDLE       = 3'd0,
        CMD_INSERT     = 3'd1,
        CMD_REMOVE     = 3'd2,
        CMD_DROP_FULL  = 3'd3,
        CMD_FAIL_EMPTY = 3'd4
    } cmd_op_t;

    typedef struct packed
    {
        cmd_op_t op;
    } cmd_t;

    // Occupancy flags from the datapath to the controller.
    typedef struct packed
    {
        logic empty;
        logic full;
    } qstat_t;

endpackage

>>> rtl/core/min_priority_queue.sv
// Top level of the sorted min priority queue.
//
// A bounded queue of QUEUE_DEPTH (16) entries, each a 32-bit data word and an
// 8-bit priority, held in ascending priority order in a row of shift-register
// cells. A smaller priority number leaves first; an insert lands behind every
// stored entry of lower or equal priority, so equal priorities leave in
// arrival order. Every input transfer yields exactly one output transfer:
// status 0 when done, 1 for a remove on an empty queue, 2 for an insert into
// a full queue (the entry is dropped). out_data and out_priority carry the
// removed head entry, and are zero for an insert or a failed operation.
// Timing: the operation executes in the cycle its input transfer is taken and
// its result appears in the output register on the next cycle, so one
// operation per clock is sustained while the output side is ready. All cells
// compare against the new priority in parallel, which sets the insert path.
// A new input is taken while a result waits, as long as that result drains in
// the same cycle. No clearing pass follows reset; the queue is ready at once.
module min_priority_queue
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // [31:0] in_data, [39:32] in_priority
    input  logic        s_tuser,   // [0] opcode
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // [31:0] out_data, [39:32] out_priority
    output logic [1:0]  m_tuser    // [1:0] status
);
    import mpq_pkg::*;

    cmd_t              cmd;
    qstat_t            qstat;
    logic [1:0]        res_status;
    logic [DATA_W-1:0] res_data;
    logic [PRIO_W-1:0] res_priority;

    // Sequence handshakes and pick the command for each transfer.
    mpq_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_opcode (s_tuser),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .qstat     (qstat),
        .cmd       (cmd)
    );

    // Hold the sorted entries and the result register.
    mpq_dpath u_dpath
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .in_data      (s_tdata[DATA_W-1:0]),
        .in_priority  (s_tdata[DATA_W+PRIO_W-1:DATA_W]),
        .qstat        (qstat),
        .res_status   (res_status),
        .res_data     (res_data),
        .res_priority (res_priority)
    );

    assign m_tdata = {res_priority, res_data};
    assign m_tuser = res_status;

endmodule

>>> rtl/core/mpq_ctrl.sv
// Controller: handshake sequencing and command selection for the queue.
module mpq_ctrl
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  logic           in_opcode,
    output logic           out_valid,
    input  logic           out_ready,
    input  mpq_pkg::qstat_t qstat,
    output mpq_pkg::cmd_t   cmd
);
    import mpq_pkg::*;

    typedef enum logic [1:0]
    {
        S_IDLE = 2'b01,
        S_HOLD = 2'b10
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   accept;

    // Take a new transfer whenever the result register is free or drains now.
    assign in_ready  = (state_reg == S_IDLE) || out_ready;
    assign accept    = in_valid && in_ready;
    assign out_valid = (state_reg == S_HOLD);

    always_comb
    begin
        cmd.op = CMD_IDLE;
        if (accept)
        begin
            if (opcode_t'(in_opcode) == OP_INSERT)
            begin
                cmd.op = qstat.full ? CMD_DROP_FULL : CMD_INSERT;
            end
            else
            begin
                cmd.op = qstat.empty ? CMD_FAIL_EMPTY : CMD_REMOVE;
            end
        end
    end

    always_comb
    begin
        state_next = state_reg;
        if (accept)
        begin
            state_next = S_HOLD;
        end
        else if ((state_reg == S_HOLD) && out_ready)
        begin
            state_next = S_IDLE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

>>> rtl/core/mpq_dpath.sv
// Datapath: sorted shift-register entry cells, entry count and result register.
module mpq_dpath
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  mpq_pkg::cmd_t                cmd,
    input  logic [mpq_pkg::DATA_W-1:0]   in_data,
    input  logic [mpq_pkg::PRIO_W-1:0]   in_priority,
    output mpq_pkg::qstat_t              qstat,
    output logic [1:0]                   res_status,
    output logic [mpq_pkg::DATA_W-1:0]   res_data,
    output logic [mpq_pkg::PRIO_W-1:0]   res_priority
);
    import mpq_pkg::*;

    logic [DATA_W-1:0] data_reg  [QUEUE_DEPTH];
    logic [PRIO_W-1:0] prio_reg  [QUEUE_DEPTH];
    logic [DATA_W-1:0] data_next [QUEUE_DEPTH];
    logic [PRIO_W-1:0] prio_next [QUEUE_DEPTH];
    logic [QUEUE_DEPTH-1:0] keep;
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;
    logic [1:0]        status_reg;
    logic [1:0]        status_next;
    logic [DATA_W-1:0] rdata_reg;
    logic [PRIO_W-1:0] rprio_reg;

    assign qstat.empty = (count_reg == '0);
    assign qstat.full  = (count_reg == CNT_W'(QUEUE_DEPTH));

    // Each cell compares against the new priority in parallel; the kept cells form a prefix.
    genvar g;
    generate
        for (g = 0; g < QUEUE_DEPTH; g++)
        begin : g_cell
            logic keep_prev;
            logic [DATA_W-1:0] up_data;
            logic [PRIO_W-1:0] up_prio;

            assign keep[g] = (CNT_W'(g) < count_reg) && (prio_reg[g] <= in_priority);

            if (g == 0)
            begin : g_head
                assign keep_prev = 1'b1;
            end
            else
            begin : g_body
                assign keep_prev = keep[g-1];
            end

            if (g == QUEUE_DEPTH - 1)
            begin : g_tail
                assign up_data = data_reg[g];
                assign up_prio = prio_reg[g];
            end
            else
            begin : g_mid
                assign up_data = data_reg[g+1];
                assign up_prio = prio_reg[g+1];
            end

            always_comb
            begin
                data_next[g] = data_reg[g];
                prio_next[g] = prio_reg[g];
                unique case (cmd.op)
                    CMD_INSERT:
                    begin
                        if (!keep[g])
                        begin
                            if (keep_prev)
                            begin
                                data_next[g] = in_data;
                                prio_next[g] = in_priority;
                            end
                            else
                            begin
                                data_next[g] = data_reg[(g == 0) ? 0 : g-1];
                                prio_next[g] = prio_reg[(g == 0) ? 0 : g-1];
                            end
                        end
                    end
                    CMD_REMOVE:
                    begin
                        data_next[g] = up_data;
                        prio_next[g] = up_prio;
                    end
                    CMD_IDLE, CMD_DROP_FULL, CMD_FAIL_EMPTY:
                    begin
                    end
                    default:
                    begin
                    end
                endcase
            end

            always_ff @(posedge clk)
            begin
                data_reg[g] <= data_next[g];
                prio_reg[g] <= prio_next[g];
            end
        end
    endgenerate

    always_comb
    begin
        count_next  = count_reg;
        status_next = status_reg;
        unique case (cmd.op)
            CMD_INSERT:
            begin
                count_next  = count_reg + CNT_W'(1);
                status_next = ST_DONE;
            end
            CMD_REMOVE:
            begin
                count_next  = count_reg - CNT_W'(1);
                status_next = ST_DONE;
            end
            CMD_DROP_FULL:
            begin
                status_next = ST_FULL;
            end
            CMD_FAIL_EMPTY:
            begin
                status_next = ST_EMPTY;
            end
            CMD_IDLE:
            begin
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    // Result register: load only when a transfer executes, zero fields unless a head leaves.
    always_ff @(posedge clk)
    begin
        if (cmd.op != CMD_IDLE)
        begin
            status_reg <= status_next;
            rdata_reg  <= (cmd.op == CMD_REMOVE) ? data_reg[0] : '0;
            rprio_reg  <= (cmd.op == CMD_REMOVE) ? prio_reg[0] : '0;
        end
    end

    assign res_status   = status_reg;
    assign res_data     = rdata_reg;
    assign res_priority = rprio_reg;

endmodule
